/* rtl/wmf_pkg.sv */
// Shared constants and types for the window median filter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package wmf_pkg;

  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int RANK_W      = IDX_W;
  localparam int CFG_W       = 5;
  localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = CFG_W'(5);

  // Operation attached to a window store read; acted on when the data returns.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_KEY,
    OP_CMP
  } rd_op_t;

  typedef struct packed {
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    rd_op_t                rd_op;
    logic                  rd_last;
    logic [RANK_W-1:0]     lo_rank;
    logic [RANK_W-1:0]     hi_rank;
    logic                  out_load;
  } wmf_cmd_t;

  typedef struct packed {
    logic out_free;
  } wmf_status_t;

endpackage

/* rtl/wmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/wmf_ctrl.sv */
// Controller: window length register, fill counter and the rank-scan sequencer.
// Depends on wmf_pkg.
`timescale 1ns / 1ps

module wmf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [wmf_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  output wmf_pkg::wmf_cmd_t         cmd,
  input  wmf_pkg::wmf_status_t      status
);
  import wmf_pkg::*;

  typedef enum logic [2:0] {
    COLLECT,
    KEY,
    SCAN,
    DRAIN,
    OUT
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] window_len;
  logic [LEN_W-1:0] fill;
  logic [IDX_W-1:0] key_i;
  logic [IDX_W-1:0] scan_j;

  logic [LEN_W-1:0] n_eff;
  logic [LEN_W-1:0] n_m1;
  logic [IDX_W-1:0] wr_idx;
  logic [LEN_W-1:0] fill_next;
  logic             scan_last;
  logic             key_last;

  always_comb begin
    if (window_len == '0) begin
      n_eff = LEN_W'(1);
    end else if (LEN_W'(window_len) > LEN_W'(MAX_WINDOW)) begin
      n_eff = LEN_W'(MAX_WINDOW);
    end else begin
      n_eff = LEN_W'(window_len);
    end
    n_m1      = n_eff - LEN_W'(1);
    // drop held samples if the length shrank to or below the fill level
    wr_idx    = (fill >= n_eff) ? '0 : fill[IDX_W-1:0];
    fill_next = {1'b0, wr_idx} + LEN_W'(1);
    scan_last = ({1'b0, scan_j} == n_m1);
    key_last  = ({1'b0, key_i} == n_m1);
  end

  always_comb begin
    s_tready      = (state == COLLECT);
    cmd           = '0;
    cmd.rd_op     = OP_NONE;
    cmd.wr_addr   = wr_idx;
    cmd.lo_rank   = RANK_W'(n_m1 >> 1);
    cmd.hi_rank   = RANK_W'(n_eff >> 1);
    case (state)
      COLLECT: begin
        cmd.wr_en = s_tvalid;
      end
      KEY: begin
        cmd.rd_op   = OP_KEY;
        cmd.rd_addr = key_i;
      end
      SCAN: begin
        cmd.rd_op   = OP_CMP;
        cmd.rd_addr = scan_j;
        cmd.rd_last = scan_last;
      end
      OUT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= COLLECT;
      window_len <= WINDOW_LEN_RESET;
      fill       <= '0;
      key_i      <= '0;
      scan_j     <= '0;
    end else begin
      if (cfg_we) begin
        window_len <= cfg_wdata;
      end
      case (state)
        COLLECT: begin
          if (s_tvalid) begin
            if (fill_next == n_eff) begin
              fill  <= '0;
              key_i <= '0;
              state <= KEY;
            end else begin
              fill <= fill_next;
            end
          end
        end
        KEY: begin
          scan_j <= '0;
          state  <= SCAN;
        end
        SCAN: begin
          if (scan_last) begin
            if (key_last) begin
              state <= DRAIN;
            end else begin
              key_i <= key_i + IDX_W'(1);
              state <= KEY;
            end
          end else begin
            scan_j <= scan_j + IDX_W'(1);
          end
        end
        DRAIN: begin
          state <= OUT;
        end
        OUT: begin
          if (status.out_free) begin
            state <= COLLECT;
          end
        end
        default: begin
          state <= COLLECT;
        end
      endcase
    end
  end

endmodule

/* rtl/wmf_dp.sv */
// Datapath: window store, rank counter, middle-element capture, averaging
// and the output register. Depends on wmf_pkg and wmf_ram.
`timescale 1ns / 1ps

module wmf_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wmf_pkg::wmf_cmd_t                    cmd,
  output wmf_pkg::wmf_status_t                 status,
  input  logic signed [wmf_pkg::SAMPLE_BITS-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic signed [wmf_pkg::SAMPLE_BITS-1:0] m_tdata
);
  import wmf_pkg::*;

  logic [SAMPLE_BITS-1:0]        rd_raw;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  rd_op_t                        op_d;
  logic [IDX_W-1:0]              addr_d;
  logic                          last_d;

  logic signed [SAMPLE_BITS-1:0] key;
  logic [IDX_W-1:0]              key_idx;
  logic [RANK_W-1:0]             rank;
  logic [RANK_W-1:0]             rank_next;
  logic signed [SAMPLE_BITS-1:0] lo_val;
  logic signed [SAMPLE_BITS-1:0] hi_val;

  logic signed [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS:0]          sum_adj;
  logic                          below;

  wmf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (s_tdata),
    .raddr (cmd.rd_addr),
    .rdata (rd_raw)
  );

  assign rd_data = $signed(rd_raw);

  // Ties break on store position so every entry gets a distinct rank.
  always_comb begin
    below     = (rd_data < key) || ((rd_data == key) && (addr_d < key_idx));
    rank_next = rank + RANK_W'(below);
    sum       = (SAMPLE_BITS + 1)'(lo_val) + (SAMPLE_BITS + 1)'(hi_val);
    // add one before the shift for negative sums: truncate toward zero
    sum_adj   = sum + {{SAMPLE_BITS{1'b0}}, sum[SAMPLE_BITS]};
  end

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_d     <= OP_NONE;
      m_tvalid <= 1'b0;
    end else begin
      op_d <= cmd.rd_op;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_d <= cmd.rd_addr;
    last_d <= cmd.rd_last;
    case (op_d)
      OP_KEY: begin
        key     <= rd_data;
        key_idx <= addr_d;
        rank    <= '0;
      end
      OP_CMP: begin
        rank <= rank_next;
        if (last_d) begin
          if (rank_next == cmd.lo_rank) begin
            lo_val <= key;
          end
          if (rank_next == cmd.hi_rank) begin
            hi_val <= key;
          end
        end
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      m_tdata <= $signed(sum_adj[SAMPLE_BITS:1]);
    end
  end

endmodule

/* rtl/window_median_filter.sv */
// Top level of the window median filter: controller, datapath and store.
// Depends on wmf_pkg, wmf_ctrl, wmf_dp and wmf_ram.
`timescale 1ns / 1ps

// Collects signed samples into a window of window_len entries (0 acts as 1,
// above 16 acts as 16) and emits one median per completed window: the middle
// sample for odd lengths, the mean of the two middle samples truncated toward
// zero for even lengths. The input takes one sample per cycle while a window
// fills. When the last sample of a window lands, one comparator ranks every
// stored entry against all entries, reading the 16-entry window store one
// entry a cycle; s_tready is low while it ranks. That single comparator and
// the one read port of the store bound the throughput: no new sample is taken
// before the window is ranked. The finished median sits in an output
// register, so the next window starts filling while it waits to be taken;
// ranking stalls only if it is still untaken when the next median is ready.
// Write window_len only while the block is idle; a shorter length that the
// held samples already meet drops them and starts a fresh window with the
// next sample. No clearing pass.

module window_median_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration: window_len
  input  logic                                   cfg_we,
  input  logic [wmf_pkg::CFG_W-1:0]              cfg_wdata,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic signed [wmf_pkg::SAMPLE_BITS-1:0] s_tdata,  // [15:0] sample
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic signed [wmf_pkg::SAMPLE_BITS-1:0] m_tdata   // [15:0] median
);
  import wmf_pkg::*;

  wmf_cmd_t    cmd;
  wmf_status_t status;

  // Sequence the fill, the rank scan and the output transfer.
  wmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // Hold the window, rank entries, average the middle pair, hold the result.
  wmf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* rtl/wmf_checker.sv */
// Port-level checks for the window median filter, bound to the top level.
// Depends on wmf_pkg and window_median_filter.
`timescale 1ns / 1ps

module wmf_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   s_tvalid,
  input logic                                   s_tready,
  input logic                                   m_tvalid,
  input logic                                   m_tready,
  input logic signed [wmf_pkg::SAMPLE_BITS-1:0] m_tdata
);
  import wmf_pkg::*;

  // Hold a stalled result and its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("median dropped or changed while stalled");

  // Clear the output after reset.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A new result appears only after ranking, never right after an input transfer.
  a_rank_gap: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("median appeared without a ranking pass");

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
